### design/cmb_pkg.sv
// ----------------------------------------------------------------------------
// cmb_pkg
// Shared types and constants for the coalescing message buffer: command codes,
// beat payload structs, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
package cmb_pkg;

    localparam int DEPTH_DEF  = 32;
    localparam int RESULT_CAP = 32;

    localparam logic [1:0] MSG_TYPE_LAST = 2'd2;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_DRAIN = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] msg_type;
        logic [3:0] channel;
        logic [6:0] number;
        logic [6:0] data_value;
        logic [5:0] max_count;
    } in_t;

    typedef struct packed {
        logic       msg_valid;
        logic [1:0] out_type;
        logic [3:0] out_channel;
        logic [6:0] out_number;
        logic [6:0] out_value;
        logic [5:0] sent_total;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [1:0] msg_type;
        logic [3:0] channel;
        logic [6:0] number;
        logic [6:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT_SCAN,
        ST_PUT_WRITE,
        ST_DRAIN_SCAN,
        ST_DRAIN_EMIT,
        ST_DRAIN_END
    } state_t;

endpackage

### design/coalescing_message_buffer.sv
// ----------------------------------------------------------------------------
// coalescing_message_buffer
// Table of pending control messages keyed by type, channel and number; a newer
// put for a key replaces the pending value, a drain emits pending entries.
// ----------------------------------------------------------------------------
// One beat is taken at a time; in_ready is low while a command is worked on.
// A put walks the whole table through the single read port of the entry
// memory, one slot a cycle, for the key match and the circular clean-slot
// search together, then writes the chosen slot.
// A drain steps through the slots in order, skipping clean slots and
// emitting each pending one, and stalls while out_ready is low and the
// output register is full. No clearing pass after reset.
module coalescing_message_buffer #(
    parameter int DEPTH = cmb_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cmb_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output cmb_pkg::out_t out_data
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int LW   = (CW > 6) ? CW : 6;
    localparam int HALF = DEPTH / 2;

    cmb_pkg::state_t state_reg, state_next;
    cmb_pkg::in_t    req_reg, req_next;
    cmb_pkg::out_t   out_data_reg, out_data_next;
    cmb_pkg::entry_t mem [DEPTH];
    cmb_pkg::entry_t rd_data_reg;
    cmb_pkg::entry_t mem_wdata;

    logic            out_valid_reg, out_valid_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   next_slot_reg, next_slot_next;
    logic [CW-1:0]   pend_cnt_reg, pend_cnt_next;
    logic [DEPTH-1:0] pending_reg, pending_next;
    logic [DEPTH-1:0] present_reg, present_next;
    logic            match_found_reg, match_found_next;
    logic [IW-1:0]   match_idx_reg, match_idx_next;
    logic            ge_found_reg, ge_found_next;
    logic [IW-1:0]   ge_idx_reg, ge_idx_next;
    logic            any_found_reg, any_found_next;
    logic [IW-1:0]   any_idx_reg, any_idx_next;
    logic [5:0]      drain_n_reg, drain_n_next;
    logic [5:0]      sent_reg, sent_next;
    logic            empty_reg, empty_next;

    logic            mem_we;
    logic [IW-1:0]   idx;
    logic [CW-1:0]   cnt_dec;
    logic [IW-1:0]   prev_idx;
    logic [IW-1:0]   target;
    logic [CW-1:0]   tgt_inc;
    logic            out_free;
    logic            accept;
    logic            scan_done;
    logic [5:0]      sent_inc;
    logic [LW-1:0]   lim_pc, lim_mc, lim_n;

    assign in_ready  = (state_reg == cmb_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign idx       = cnt_reg[IW-1:0];
    assign cnt_dec   = cnt_reg - CW'(1);
    assign prev_idx  = cnt_dec[IW-1:0];
    assign scan_done = (sent_reg == drain_n_reg) || (cnt_reg == CW'(DEPTH));
    assign sent_inc  = sent_reg + 6'd1;

    assign target = match_found_reg ? match_idx_reg :
                    ge_found_reg    ? ge_idx_reg    :
                    any_found_reg   ? any_idx_reg   : next_slot_reg;
    assign tgt_inc = CW'(target) + CW'(1);

    always_comb
    begin
        lim_pc = LW'(pend_cnt_reg);
        lim_mc = LW'(in_data.max_count);
        lim_n  = lim_pc;
        if (lim_mc != '0 && lim_mc < lim_n)
        begin
            lim_n = lim_mc;
        end
        if (lim_n > LW'(cmb_pkg::RESULT_CAP))
        begin
            lim_n = LW'(cmb_pkg::RESULT_CAP);
        end
    end

    always_comb
    begin
        mem_wdata.msg_type = req_reg.msg_type;
        mem_wdata.channel  = req_reg.channel;
        mem_wdata.number   = req_reg.number;
        mem_wdata.value    = req_reg.data_value;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cmb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.cmd == cmb_pkg::CMD_PUT &&
                        in_data.msg_type <= cmb_pkg::MSG_TYPE_LAST)
                    begin
                        state_next = cmb_pkg::ST_PUT_SCAN;
                    end
                    else if (in_data.cmd == cmb_pkg::CMD_DRAIN)
                    begin
                        state_next = (pend_cnt_reg == '0) ? cmb_pkg::ST_DRAIN_EMIT
                                                         : cmb_pkg::ST_DRAIN_SCAN;
                    end
                end
            end
            cmb_pkg::ST_PUT_SCAN:
            begin
                if (cnt_reg == CW'(DEPTH))
                begin
                    state_next = cmb_pkg::ST_PUT_WRITE;
                end
            end
            cmb_pkg::ST_PUT_WRITE:
            begin
                state_next = cmb_pkg::ST_IDLE;
            end
            cmb_pkg::ST_DRAIN_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = cmb_pkg::ST_DRAIN_END;
                end
                else if (pending_reg[idx])
                begin
                    state_next = cmb_pkg::ST_DRAIN_EMIT;
                end
            end
            cmb_pkg::ST_DRAIN_EMIT:
            begin
                if (out_free)
                begin
                    state_next = empty_reg ? cmb_pkg::ST_IDLE : cmb_pkg::ST_DRAIN_SCAN;
                end
            end
            cmb_pkg::ST_DRAIN_END:
            begin
                state_next = cmb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cmb_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next         = req_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        cnt_next         = cnt_reg;
        next_slot_next   = next_slot_reg;
        pend_cnt_next    = pend_cnt_reg;
        pending_next     = pending_reg;
        present_next     = present_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        ge_found_next    = ge_found_reg;
        ge_idx_next      = ge_idx_reg;
        any_found_next   = any_found_reg;
        any_idx_next     = any_idx_reg;
        drain_n_next     = drain_n_reg;
        sent_next        = sent_reg;
        empty_next       = empty_reg;
        mem_we           = 1'b0;

        case (state_reg)
            cmb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next         = in_data;
                    cnt_next         = '0;
                    match_found_next = 1'b0;
                    ge_found_next    = 1'b0;
                    any_found_next   = 1'b0;
                    sent_next        = '0;
                    drain_n_next     = lim_n[5:0];
                    empty_next       = (pend_cnt_reg == '0);
                    if (in_data.cmd == cmb_pkg::CMD_CLEAR)
                    begin
                        pending_next   = '0;
                        present_next   = '0;
                        next_slot_next = '0;
                        pend_cnt_next  = '0;
                    end
                end
            end
            cmb_pkg::ST_PUT_SCAN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg != CW'(DEPTH) && !pending_reg[idx])
                begin
                    if (!any_found_reg)
                    begin
                        any_found_next = 1'b1;
                        any_idx_next   = idx;
                    end
                    if (!ge_found_reg && idx >= next_slot_reg)
                    begin
                        ge_found_next = 1'b1;
                        ge_idx_next   = idx;
                    end
                end
                if (cnt_reg != '0 && !match_found_reg && present_reg[prev_idx] &&
                    rd_data_reg.msg_type == req_reg.msg_type &&
                    rd_data_reg.channel == req_reg.channel &&
                    rd_data_reg.number == req_reg.number)
                begin
                    match_found_next = 1'b1;
                    match_idx_next   = prev_idx;
                end
            end
            cmb_pkg::ST_PUT_WRITE:
            begin
                mem_we = 1'b1;
                if (match_found_reg)
                begin
                    if (!pending_reg[target])
                    begin
                        pending_next[target] = 1'b1;
                        pend_cnt_next        = pend_cnt_reg + CW'(1);
                    end
                end
                else
                begin
                    pending_next[target] = 1'b1;
                    present_next[target] = 1'b1;
                    if (ge_found_reg || any_found_reg)
                    begin
                        pend_cnt_next = pend_cnt_reg + CW'(1);
                    end
                    next_slot_next = (tgt_inc == CW'(DEPTH)) ? '0 : tgt_inc[IW-1:0];
                end
            end
            cmb_pkg::ST_DRAIN_SCAN:
            begin
                if (!scan_done && !pending_reg[idx])
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            cmb_pkg::ST_DRAIN_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (empty_reg)
                    begin
                        out_data_next      = '0;
                        out_data_next.last = 1'b1;
                    end
                    else
                    begin
                        out_data_next.msg_valid   = 1'b1;
                        out_data_next.out_type    = rd_data_reg.msg_type;
                        out_data_next.out_channel = rd_data_reg.channel;
                        out_data_next.out_number  = rd_data_reg.number;
                        out_data_next.out_value   = rd_data_reg.value;
                        out_data_next.sent_total  = sent_inc;
                        out_data_next.last        = (sent_inc == drain_n_reg);
                        pending_next[idx]         = 1'b0;
                        pend_cnt_next             = pend_cnt_reg - CW'(1);
                        sent_next                 = sent_inc;
                        cnt_next                  = cnt_reg + CW'(1);
                    end
                end
            end
            cmb_pkg::ST_DRAIN_END:
            begin
                if (pend_cnt_reg == '0 && CW'(next_slot_reg) > CW'(HALF))
                begin
                    present_next   = '0;
                    next_slot_next = '0;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[target] <= mem_wdata;
        end
        rd_data_reg <= mem[idx];
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        out_data_reg   <= out_data_next;
        match_idx_reg  <= match_idx_next;
        ge_idx_reg     <= ge_idx_next;
        any_idx_reg    <= any_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cmb_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            next_slot_reg   <= '0;
            pend_cnt_reg    <= '0;
            pending_reg     <= '0;
            present_reg     <= '0;
            match_found_reg <= 1'b0;
            ge_found_reg    <= 1'b0;
            any_found_reg   <= 1'b0;
            drain_n_reg     <= '0;
            sent_reg        <= '0;
            empty_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            cnt_reg         <= cnt_next;
            next_slot_reg   <= next_slot_next;
            pend_cnt_reg    <= pend_cnt_next;
            pending_reg     <= pending_next;
            present_reg     <= present_next;
            match_found_reg <= match_found_next;
            ge_found_reg    <= ge_found_next;
            any_found_reg   <= any_found_next;
            drain_n_reg     <= drain_n_next;
            sent_reg        <= sent_next;
            empty_reg       <= empty_next;
        end
    end

endmodule
